// ===== rtl/core/aabb_frustum_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frustum classifier
// Shared concurrent assertion forms used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CLASSIFIER_ASSERT_SVH
`define AABB_FRUSTUM_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/aff_pkg.sv =====
// ----------------------------------------------------------------------------
// aff_pkg
// Types and constants shared by the frustum classifier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aff_pkg;

    // Item kinds carried in the action field.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    // Axis step codes of the multiply-accumulate sequence.
    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_Z     = 2'd2;
    localparam logic [1:0] AXIS_DRAIN = 2'd3;

    // Datapath widths. 2m and 2n carry 30 fraction bits.
    localparam int PROD_M_W = 49;
    localparam int PROD_N_W = 48;
    localparam int ACC_M_W  = 53;
    localparam int ACC_N_W  = 52;
    localparam int CMP_W    = 55;
    localparam int D_SHIFT  = 15;

    typedef enum logic [1:0] {
        VIS_INSIDE    = 2'd0,
        VIS_INTERSECT = 2'd1,
        VIS_OUTSIDE   = 2'd2
    } t_vis;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_CMP,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic signed [31:0] d;
    } t_plane;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } t_box;

    typedef struct packed {
        logic       load_box;
        logic       init;
        logic       mul_en;
        logic       acc_en;
        logic [1:0] axis;
    } t_mac_ctrl;

    typedef struct packed {
        logic far_neg;
        logic near_neg;
    } t_mac_stat;

    typedef struct packed {
        logic load;
        t_vis vis;
    } t_seq_result;

endpackage

// ===== rtl/core/aff_channels.sv =====
// ----------------------------------------------------------------------------
// Frustum classifier channels
// Valid/ready interfaces for the item input and the result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aff_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic        [2:0]  plane_index;
    logic signed [15:0] plane_a;
    logic signed [15:0] plane_b;
    logic signed [15:0] plane_c;
    logic signed [31:0] plane_d;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;

    modport source (
        output valid, action, plane_index, plane_a, plane_b, plane_c, plane_d,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, action, plane_index, plane_a, plane_b, plane_c, plane_d,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface aff_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] visibility;

    modport source (output valid, visibility, input ready);
    modport sink   (input valid, visibility, output ready);
endinterface

// ===== rtl/core/aabb_frustum_classifier.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_classifier
// A test box is classified plane by plane; a load item is written into the
// plane store at its transfer. No new item is taken until the verdict of a
// box test is in the result register, since the single multiply-accumulate
// unit takes each plane through the x, y, z and drain steps and a compare.
// Reset: synchronous, active low; all planes return to zero and the result
// register empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "aabb_frustum_classifier_assert.svh"

module aabb_frustum_classifier import aff_pkg::*; #(
    parameter int NUM_PLANES = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aff_in_if.sink        i_in,
    aff_out_if.source     o_out
);

    localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    // A transfer on the input is either a plane load, which is written into
    // the plane store in the same cycle, or a box test, which starts the
    // sequencer. The input is ready only while the sequencer is idle.
    logic             w_in_fire;
    logic             w_load_fire;
    logic             w_test_fire;
    logic             w_out_free;
    t_plane           w_wr_plane;
    t_plane           w_rd_plane;
    t_box             w_box;
    t_mac_ctrl        w_ctrl;
    t_mac_stat        w_stat;
    t_seq_result      w_result;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_ready;

    logic             r_out_valid;
    logic [1:0]       r_out_vis;

    assign w_in_fire   = i_in.valid && w_ready;
    assign w_load_fire = w_in_fire && (i_in.action == ACT_LOAD);
    assign w_test_fire = w_in_fire && (i_in.action == ACT_TEST);

    assign w_wr_plane.a = i_in.plane_a;
    assign w_wr_plane.b = i_in.plane_b;
    assign w_wr_plane.c = i_in.plane_c;
    assign w_wr_plane.d = i_in.plane_d;

    assign w_box.min_x = i_in.box_min_x;
    assign w_box.min_y = i_in.box_min_y;
    assign w_box.min_z = i_in.box_min_z;
    assign w_box.max_x = i_in.box_max_x;
    assign w_box.max_y = i_in.box_max_y;
    assign w_box.max_z = i_in.box_max_z;

    aff_plane_store #(
        .NUM_PLANES (NUM_PLANES),
        .IDX_W      (IDX_W)
    ) u_plane_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_load_fire),
        .i_wr_idx   (i_in.plane_index),
        .i_wr_plane (w_wr_plane),
        .i_rd_idx   (w_rd_idx),
        .o_rd_plane (w_rd_plane)
    );

    // The shared unit computes 2m and 2n for the plane the sequencer selects,
    // one axis per cycle, and reports the signs of 2m + 2n and 2m - 2n.
    aff_mac_unit u_mac_unit (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_box   (w_box),
        .i_plane (w_rd_plane),
        .o_stat  (w_stat)
    );

    aff_sequencer #(
        .NUM_PLANES (NUM_PLANES),
        .IDX_W      (IDX_W)
    ) u_sequencer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_test_start (w_test_fire),
        .i_stat       (w_stat),
        .i_out_free   (w_out_free),
        .o_ready      (w_ready),
        .o_ctrl       (w_ctrl),
        .o_rd_idx     (w_rd_idx),
        .o_result     (w_result)
    );

    // The result register separates the two sides: loads and further tests
    // are accepted while a finished verdict waits for its transfer.
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.load) begin
            r_out_vis <= w_result.vis;
        end
    end

    assign i_in.ready       = w_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.visibility = r_out_vis;

    // A box test keeps the input closed on the following cycle.
    `AFF_ASSERT_NEXT(a_test_blocks_input, i_clk, i_rst_n, w_test_fire, !i_in.ready, "input ready right after a box test transfer")
    // A verdict is written only into an empty or draining result register.
    `AFF_ASSERT_IMP(a_result_no_overwrite, i_clk, i_rst_n, w_result.load, !r_out_valid || o_out.ready, "result register overwritten before transfer")
    // A written verdict is presented on the next cycle.
    `AFF_ASSERT_NEXT(a_result_presented, i_clk, i_rst_n, w_result.load, o_out.valid && (o_out.visibility == $past(w_result.vis)), "written verdict not presented")

endmodule

// ===== rtl/core/aff_plane_store.sv =====
// ----------------------------------------------------------------------------
// aff_plane_store
// Register file holding the frustum planes, cleared to zero by reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aff_plane_store import aff_pkg::*; #(
    parameter int NUM_PLANES = 6,
    parameter int IDX_W      = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [2:0]       i_wr_idx,
    input  t_plane           i_wr_plane,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_plane           o_rd_plane
);

    t_plane r_planes [NUM_PLANES];

    // Indexes at or above the plane count match no entry and are dropped.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            if (!i_rst_n) begin
                r_planes[i] <= '0;
            end else if (i_wr_en && (int'(i_wr_idx) == i)) begin
                r_planes[i] <= i_wr_plane;
            end
        end
    end

    assign o_rd_plane = r_planes[i_rd_idx];

endmodule

// ===== rtl/core/aff_mac_unit.sv =====
// ----------------------------------------------------------------------------
// aff_mac_unit
// Shared multiply-accumulate unit forming 2m and 2n one axis at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aff_mac_unit import aff_pkg::*; (
    input  logic      i_clk,
    input  t_mac_ctrl i_ctrl,
    input  t_box      i_box,
    input  t_plane    i_plane,
    output t_mac_stat o_stat
);

    t_box                       r_box;
    logic signed [PROD_M_W-1:0] r_prod_m;
    logic        [PROD_N_W-1:0] r_prod_n;
    logic        [ACC_M_W-1:0]  r_acc_m;
    logic        [ACC_N_W-1:0]  r_acc_n;

    logic signed [31:0]         w_lo;
    logic signed [31:0]         w_hi;
    logic signed [15:0]         w_p;
    logic signed [32:0]         w_sum;
    logic        [32:0]         w_diff;
    logic        [32:0]         w_diff_abs;
    logic        [15:0]         w_p_abs;
    logic signed [PROD_M_W-1:0] n_prod_m;
    logic        [PROD_N_W-1:0] n_prod_n;
    logic        [CMP_W-1:0]    w_m_ext;
    logic        [CMP_W-1:0]    w_n_ext;
    logic        [CMP_W-1:0]    w_far;
    logic        [CMP_W-1:0]    w_near;

    always_comb begin
        case (i_ctrl.axis)
            AXIS_Y: begin
                w_lo = r_box.min_y;
                w_hi = r_box.max_y;
                w_p  = i_plane.b;
            end
            AXIS_Z: begin
                w_lo = r_box.min_z;
                w_hi = r_box.max_z;
                w_p  = i_plane.c;
            end
            default: begin
                w_lo = r_box.min_x;
                w_hi = r_box.max_x;
                w_p  = i_plane.a;
            end
        endcase
    end

    // The absolute difference of two 32-bit values always fits 32 bits.
    assign w_sum      = {w_lo[31], w_lo} + {w_hi[31], w_hi};
    assign w_diff     = {w_hi[31], w_hi} - {w_lo[31], w_lo};
    assign w_diff_abs = w_diff[32] ? (33'd0 - w_diff) : w_diff;
    assign w_p_abs    = w_p[15] ? (16'd0 - w_p) : w_p;
    assign n_prod_m   = w_sum * w_p;
    assign n_prod_n   = w_diff_abs[31:0] * w_p_abs;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_box) begin
            r_box <= i_box;
        end
        if (i_ctrl.mul_en) begin
            r_prod_m <= n_prod_m;
            r_prod_n <= n_prod_n;
        end
        if (i_ctrl.init) begin
            r_acc_m <= {{(ACC_M_W - 32 - D_SHIFT){i_plane.d[31]}}, i_plane.d, D_SHIFT'(0)};
            r_acc_n <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc_m <= r_acc_m + {{(ACC_M_W - PROD_M_W){r_prod_m[PROD_M_W-1]}}, r_prod_m};
            r_acc_n <= r_acc_n + {{(ACC_N_W - PROD_N_W){1'b0}}, r_prod_n};
        end
    end

    assign w_m_ext = {{(CMP_W - ACC_M_W){r_acc_m[ACC_M_W-1]}}, r_acc_m};
    assign w_n_ext = {{(CMP_W - ACC_N_W){1'b0}}, r_acc_n};
    assign w_far   = w_m_ext + w_n_ext;
    assign w_near  = w_m_ext - w_n_ext;

    assign o_stat.far_neg  = w_far[CMP_W-1];
    assign o_stat.near_neg = w_near[CMP_W-1];

endmodule

// ===== rtl/core/aff_sequencer.sv =====
// ----------------------------------------------------------------------------
// aff_sequencer
// Walks planes and axes through the shared unit and folds the plane verdicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aff_sequencer import aff_pkg::*; #(
    parameter int NUM_PLANES = 6,
    parameter int IDX_W      = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_test_start,
    input  t_mac_stat        i_stat,
    input  logic             i_out_free,
    output logic             o_ready,
    output t_mac_ctrl        o_ctrl,
    output logic [IDX_W-1:0] o_rd_idx,
    output t_seq_result      o_result
);

    t_seq_state       r_state;
    t_seq_state       n_state;
    logic [1:0]       r_axis;
    logic [1:0]       n_axis;
    logic [IDX_W-1:0] r_plane;
    logic [IDX_W-1:0] n_plane;
    logic             r_outside;
    logic             n_outside;
    logic             r_crossing;
    logic             n_crossing;
    logic             w_last_plane;

    assign w_last_plane = (r_plane == IDX_W'(NUM_PLANES - 1));

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_plane    = r_plane;
        n_outside  = r_outside;
        n_crossing = r_crossing;
        case (r_state)
            S_IDLE: begin
                if (i_test_start) begin
                    n_state    = S_MAC;
                    n_axis     = AXIS_X;
                    n_plane    = '0;
                    n_outside  = 1'b0;
                    n_crossing = 1'b0;
                end
            end
            S_MAC: begin
                if (r_axis == AXIS_DRAIN) begin
                    n_state = S_CMP;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_CMP: begin
                if (i_stat.far_neg) begin
                    n_outside = 1'b1;
                end else if (i_stat.near_neg) begin
                    n_crossing = 1'b1;
                end
                if (w_last_plane) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MAC;
                    n_axis  = AXIS_X;
                    n_plane = r_plane + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready         = 1'b0;
        o_ctrl          = '0;
        o_ctrl.axis     = r_axis;
        o_result.load   = 1'b0;
        o_result.vis    = VIS_INSIDE;
        case (r_state)
            S_IDLE: begin
                o_ready         = 1'b1;
                o_ctrl.load_box = i_test_start;
            end
            S_MAC: begin
                o_ctrl.init   = (r_axis == AXIS_X);
                o_ctrl.acc_en = (r_axis != AXIS_X);
                o_ctrl.mul_en = (r_axis != AXIS_DRAIN);
            end
            S_DONE: begin
                o_result.load = i_out_free;
                if (r_outside) begin
                    o_result.vis = VIS_OUTSIDE;
                end else if (r_crossing) begin
                    o_result.vis = VIS_INTERSECT;
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign o_rd_idx = r_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_axis     <= AXIS_X;
            r_plane    <= '0;
            r_outside  <= 1'b0;
            r_crossing <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_axis     <= n_axis;
            r_plane    <= n_plane;
            r_outside  <= n_outside;
            r_crossing <= n_crossing;
        end
    end

endmodule

// ===== test/aabb_frustum_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_classifier_tb
// Self-checking bench for the box-versus-frustum classifier. Plane loads and
// box tests go in through the item channel. Each accepted test is predicted
// here from a private copy of the six planes. The result channel is checked
// in order, with random idling on both sides and one long result back-pressure.
// ----------------------------------------------------------------------------

module aabb_frustum_classifier_tb import aff_pkg::*;;

    localparam int NUM_PLANES     = 6;
    localparam int ITEM_TARGET    = 1050;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 5 * NUM_PLANES + 2 + 8;

    // Handy fixed-point values: normals are Q2.14, offsets and corners Q16.16.
    localparam logic [15:0] NRM_ONE = 16'h4000;
    localparam logic [15:0] NRM_MAX = 16'h7FFF;
    localparam logic [15:0] NRM_MIN = 16'h8000;
    localparam logic [31:0] FX_ONE  = 32'h0001_0000;
    localparam logic [31:0] FX_TWO  = 32'h0002_0000;
    localparam logic [31:0] FX_NEG1 = 32'hFFFF_0000;
    localparam logic [31:0] FX_NEG2 = 32'hFFFE_0000;
    localparam logic [31:0] FX_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] FX_MIN  = 32'h8000_0000;

    // One item as the bench sees it: both halves are always driven, and the
    // half that the action does not use carries junk.
    typedef struct packed {
        logic       action;
        logic [2:0] idx;
        t_plane     plane;
        t_box       box;
    } t_item;

    // One row of the directed table. When fixed_exp is set, vis is the result
    // that the row must give; otherwise the row is checked against the predictor.
    typedef struct {
        logic        action;
        logic [2:0]  idx;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [31:0] d;
        logic [31:0] lo_x;
        logic [31:0] lo_y;
        logic [31:0] lo_z;
        logic [31:0] hi_x;
        logic [31:0] hi_y;
        logic [31:0] hi_z;
        bit          fixed_exp;
        t_vis        vis;
    } t_dir_row;

    localparam int DIR_N = 25;

    t_dir_row dir_table [DIR_N] = '{
        // Fresh from reset every plane is zero, so even the widest box is inside.
        // The plane fields on a test item are junk and must be ignored.
        '{ACT_TEST, 3'd0, 16'h1234, 16'hFEDC, 16'h8001, 32'hDEAD_BEEF,
          FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, 1'b1, VIS_INSIDE},
        // Loads to indexes past the last plane are dropped.
        '{ACT_LOAD, 3'd6, NRM_ONE, NRM_ONE, NRM_ONE, FX_MIN,
          FX_ONE, FX_ONE, FX_ONE, FX_TWO, FX_TWO, FX_TWO, 1'b0, VIS_INSIDE},
        '{ACT_LOAD, 3'd7, NRM_MIN, NRM_MAX, NRM_MIN, FX_MIN,
          FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, 1'b0, VIS_INSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_NEG1, FX_NEG1, FX_NEG1, FX_ONE, FX_ONE, FX_ONE, 1'b1, VIS_INSIDE},
        // Plane 0 becomes x >= 0; the box fields here are junk.
        '{ACT_LOAD, 3'd0, NRM_ONE, 16'h0000, 16'h0000, 32'h0,
          FX_MIN, FX_MAX, FX_NEG2, FX_TWO, FX_MIN, FX_MAX, 1'b0, VIS_INSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_ONE, FX_NEG1, FX_NEG1, FX_TWO, FX_ONE, FX_ONE, 1'b1, VIS_INSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_NEG2, FX_NEG1, FX_NEG1, FX_NEG1, FX_ONE, FX_ONE, 1'b1, VIS_OUTSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_NEG1, FX_NEG1, FX_NEG1, FX_ONE, FX_ONE, FX_ONE, 1'b1, VIS_INTERSECT},
        // Swapped corners give the same answer as the ordered box.
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_ONE, FX_NEG1, FX_NEG1, FX_NEG1, FX_ONE, FX_ONE, 1'b1, VIS_INTERSECT},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_NEG1, FX_NEG1, FX_NEG1, FX_NEG2, FX_ONE, FX_ONE, 1'b1, VIS_OUTSIDE},
        // A box touching the plane from the inside (m - n = 0) is still inside.
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          32'h0, FX_NEG1, FX_NEG1, FX_ONE, FX_ONE, FX_ONE, 1'b1, VIS_INSIDE},
        // Touching from the outside (m + n = 0) is not outside.
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_NEG1, FX_NEG1, FX_NEG1, 32'h0, FX_ONE, FX_ONE, 1'b1, VIS_INTERSECT},
        // Extreme normals and offsets, against extreme boxes.
        '{ACT_LOAD, 3'd5, 16'h0000, 16'h0000, NRM_MIN, FX_MAX,
          FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN, 1'b0, VIS_INSIDE},
        '{ACT_LOAD, 3'd1, NRM_MAX, NRM_MAX, NRM_MAX, FX_MIN,
          FX_NEG1, FX_NEG1, FX_NEG1, FX_NEG1, FX_NEG1, FX_NEG1, 1'b0, VIS_INSIDE},
        '{ACT_LOAD, 3'd2, NRM_MIN, NRM_MIN, NRM_MIN, FX_MAX,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, VIS_INSIDE},
        '{ACT_TEST, 3'd3, NRM_MAX, NRM_MIN, NRM_MAX, FX_MIN,
          FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, 1'b0, VIS_INSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b0, VIS_INSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0, VIS_INSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN, 1'b0, VIS_INSIDE},
        '{ACT_LOAD, 3'd3, NRM_ONE, NRM_MIN, NRM_MAX, 32'h0,
          FX_TWO, FX_TWO, FX_TWO, FX_NEG2, FX_NEG2, FX_NEG2, 1'b0, VIS_INSIDE},
        '{ACT_LOAD, 3'd4, 16'hFFFF, 16'h0001, 16'hC000, 32'hFFFF_FFFF,
          FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1'b0, VIS_INSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_MIN, FX_NEG1, 32'h0, FX_ONE, FX_MAX, FX_MAX, 1'b0, VIS_INSIDE},
        // A zero normal with a negative offset rejects every box.
        '{ACT_LOAD, 3'd0, 16'h0000, 16'h0000, 16'h0000, FX_NEG1,
          FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b0, VIS_INSIDE},
        '{ACT_TEST, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_NEG1, FX_NEG1, FX_NEG1, FX_ONE, FX_ONE, FX_ONE, 1'b1, VIS_OUTSIDE},
        '{ACT_LOAD, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0,
          FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0, VIS_INSIDE}
    };

    logic clk;
    logic rst_n;

    aff_in_if  in_ch ();
    aff_out_if out_ch ();

    aabb_frustum_classifier #(
        .NUM_PLANES(NUM_PLANES)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Private copy of the plane store, updated at every accepted load.
    t_plane plane_store [NUM_PLANES];

    // Visibility of every accepted box whose result has not come back yet.
    t_vis   vis_pending_q [$];

    int     err_count;
    int     n_tests;
    int     n_loads;
    int     n_dropped;
    int     vis_seen [4];
    int     stall_cycles;
    bit     steady_run;    // when set neither side idles
    bit     rx_hold_req;   // asks the result side for one long hold-off

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Classifies a box against the stored planes with center and extent terms,
    // both doubled and carried with 30 fraction bits in 64-bit integers.
    function automatic t_vis classify_box(t_box bx);
        longint lo [3];
        longint hi [3];
        longint nrm [3];
        longint center2;
        longint extent2;
        longint span;
        longint mag;
        bit     outside;
        bit     crossing;
        lo[0] = $signed(bx.min_x);
        lo[1] = $signed(bx.min_y);
        lo[2] = $signed(bx.min_z);
        hi[0] = $signed(bx.max_x);
        hi[1] = $signed(bx.max_y);
        hi[2] = $signed(bx.max_z);
        outside  = 1'b0;
        crossing = 1'b0;
        for (int i = 0; i < NUM_PLANES; i++) begin
            nrm[0]  = $signed(plane_store[i].a);
            nrm[1]  = $signed(plane_store[i].b);
            nrm[2]  = $signed(plane_store[i].c);
            // The offset is Q16.16: doubling and moving to 30 fraction bits
            // is a factor of 2 * 2^14.
            center2 = longint'($signed(plane_store[i].d)) * 32768;
            extent2 = 0;
            for (int k = 0; k < 3; k++) begin
                center2 += (lo[k] + hi[k]) * nrm[k];
                span = hi[k] - lo[k];
                if (span < 0) span = -span;
                mag = (nrm[k] < 0) ? -nrm[k] : nrm[k];
                extent2 += span * mag;
            end
            if (center2 + extent2 < 0) outside = 1'b1;
            else if (center2 - extent2 < 0) crossing = 1'b1;
        end
        if (outside) return VIS_OUTSIDE;
        if (crossing) return VIS_INTERSECT;
        return VIS_INSIDE;
    endfunction

    // Field values that favor the corners of the range.
    function automatic logic [31:0] pick_word32();
        case ($urandom_range(5))
            0: return FX_MIN;
            1: return FX_MAX;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_word16();
        case ($urandom_range(5))
            0: return NRM_MIN;
            1: return NRM_MAX;
            2: return 16'h0;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // A plane that is either unused (zero normal), drawn from the whole range,
    // or scaled so that boxes near the origin land on both sides of it.
    function automatic t_plane gen_plane(bit active, bit wide);
        t_plane p;
        p = '0;
        if (!active) begin
            if ($urandom_range(7) == 0) p.d = $urandom();
        end else if (wide) begin
            p.a = pick_word16();
            p.b = pick_word16();
            p.c = pick_word16();
            p.d = pick_word32();
        end else begin
            p.a = 16'($urandom());
            p.b = 16'($urandom());
            p.c = 16'($urandom());
            p.d = 32'($urandom_range(0, 1 << 22));
            if ($urandom_range(3) == 0) p.d = -p.d;
        end
        return p;
    endfunction

    // A box either from the whole range or built around a center near the
    // origin, with extents of many sizes and now and then swapped corners.
    function automatic t_box gen_box(bit wide);
        t_box        bx;
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        logic [31:0] ctr;
        logic [31:0] half;
        logic [31:0] tmp;
        for (int k = 0; k < 3; k++) begin
            if (wide) begin
                lo[k] = pick_word32();
                hi[k] = pick_word32();
            end else begin
                ctr   = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
                half  = 32'($urandom_range(0, 1 << $urandom_range(4, 21)));
                lo[k] = ctr - half;
                hi[k] = ctr + half;
                if ($urandom_range(7) == 0) begin
                    tmp   = lo[k];
                    lo[k] = hi[k];
                    hi[k] = tmp;
                end
            end
        end
        bx.min_x = lo[0];
        bx.min_y = lo[1];
        bx.min_z = lo[2];
        bx.max_x = hi[0];
        bx.max_y = hi[1];
        bx.max_z = hi[2];
        return bx;
    endfunction

    // Offers one item, idling first at random, and waits for its transfer.
    // On the transfer the plane copy is updated or the expected visibility
    // is queued: the fixed one if given, else the predicted one.
    task automatic send_item(t_item it, bit fixed_exp, t_vis fixed_vis);
        while (!steady_run && $urandom_range(99) < 34) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= it.action;
        in_ch.plane_index <= it.idx;
        in_ch.plane_a     <= it.plane.a;
        in_ch.plane_b     <= it.plane.b;
        in_ch.plane_c     <= it.plane.c;
        in_ch.plane_d     <= it.plane.d;
        in_ch.box_min_x   <= it.box.min_x;
        in_ch.box_min_y   <= it.box.min_y;
        in_ch.box_min_z   <= it.box.min_z;
        in_ch.box_max_x   <= it.box.max_x;
        in_ch.box_max_y   <= it.box.max_y;
        in_ch.box_max_z   <= it.box.max_z;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        if (it.action == ACT_LOAD) begin
            n_loads++;
            if (it.idx < NUM_PLANES) plane_store[it.idx] = it.plane;
            else n_dropped++;
        end else begin
            n_tests++;
            vis_pending_q.push_back(fixed_exp ? fixed_vis : classify_box(it.box));
        end
    endtask

    // Drops valid and waits until every queued visibility has come back.
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (vis_pending_q.size() != 0) @(posedge clk);
    endtask

    // Result side: random ready, steady ready during the steady stretch, and one
    // long hold-off that lets the block fill up and push back on its input.
    initial begin
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (steady_run) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 34);
            end
        end
    end

    // Every result transfer is matched with the oldest expected visibility.
    always @(posedge clk) begin
        t_vis want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            vis_seen[out_ch.visibility]++;
            if (vis_pending_q.size() == 0) begin
                $error("visibility %0d arrived with no box waiting for it",
                       out_ch.visibility);
                err_count++;
            end else begin
                want = vis_pending_q.pop_front();
                if (out_ch.visibility !== want) begin
                    $error("visibility mismatch: expected %0d, actual %0d",
                           want, out_ch.visibility);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without any transfer ends the run.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", stall_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, then random scenes until enough
    // useful items have gone in, then wait for the last results.
    initial begin
        t_item it;
        bit    wide;
        bit    hold_issued;
        bit    mid_pause_done;
        int    active;
        int    n_box;
        int    useful;

        err_count       = 0;
        n_tests         = 0;
        n_loads         = 0;
        n_dropped       = 0;
        vis_seen        = '{default: 0};
        stall_cycles    = 0;
        steady_run      = 1'b0;
        rx_hold_req     = 1'b0;
        hold_issued     = 1'b0;
        mid_pause_done  = 1'b0;
        foreach (plane_store[i]) plane_store[i] = '0;

        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_LOAD;
        in_ch.plane_index = '0;
        in_ch.plane_a     = '0;
        in_ch.plane_b     = '0;
        in_ch.plane_c     = '0;
        in_ch.plane_d     = '0;
        in_ch.box_min_x   = '0;
        in_ch.box_min_y   = '0;
        in_ch.box_min_z   = '0;
        in_ch.box_max_x   = '0;
        in_ch.box_max_y   = '0;
        in_ch.box_max_z   = '0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[r]) begin
            it.action      = dir_table[r].action;
            it.idx         = dir_table[r].idx;
            it.plane.a     = dir_table[r].a;
            it.plane.b     = dir_table[r].b;
            it.plane.c     = dir_table[r].c;
            it.plane.d     = dir_table[r].d;
            it.box.min_x   = dir_table[r].lo_x;
            it.box.min_y   = dir_table[r].lo_y;
            it.box.min_z   = dir_table[r].lo_z;
            it.box.max_x   = dir_table[r].hi_x;
            it.box.max_y   = dir_table[r].hi_y;
            it.box.max_z   = dir_table[r].hi_z;
            send_item(it, dir_table[r].fixed_exp, dir_table[r].vis);
        end

        // The sender holds off here until the directed results are all back.
        wait_results();

        // Each scene loads a fresh set of planes, some of them left at zero,
        // then tests a run of boxes. Stray loads to unused indexes and plane
        // changes in the middle of a run break the pattern now and then.
        useful = n_tests + n_loads - n_dropped;
        while (useful < ITEM_TARGET) begin
            steady_run = (useful >= 400 && useful < 600);
            if (!hold_issued && useful >= 150) begin
                rx_hold_req = 1'b1;
                hold_issued = 1'b1;
            end
            if (!mid_pause_done && useful >= 700) begin
                wait_results();
                mid_pause_done = 1'b1;
            end

            wide   = ($urandom_range(4) == 0);
            active = $urandom_range(1, NUM_PLANES);
            for (int p = 0; p < NUM_PLANES; p++) begin
                it.action = ACT_LOAD;
                it.idx    = 3'(p);
                it.plane  = gen_plane(p < active, wide);
                it.box    = gen_box(1'b1);
                send_item(it, 1'b0, VIS_INSIDE);
                if ($urandom_range(5) == 0) begin
                    it.idx   = 3'($urandom_range(NUM_PLANES, 7));
                    it.plane = gen_plane(1'b1, 1'b1);
                    send_item(it, 1'b0, VIS_INSIDE);
                end
            end

            n_box = $urandom_range(3, 14);
            for (int b = 0; b < n_box; b++) begin
                if ($urandom_range(9) == 0) begin
                    it.action = ACT_LOAD;
                    it.idx    = 3'($urandom_range(0, NUM_PLANES - 1));
                    it.plane  = gen_plane(1'b1, wide);
                    it.box    = gen_box(1'b1);
                    send_item(it, 1'b0, VIS_INSIDE);
                end
                it.action = ACT_TEST;
                it.idx    = 3'($urandom());
                it.plane  = gen_plane(1'b1, 1'b1);
                it.box    = gen_box(wide);
                send_item(it, 1'b0, VIS_INSIDE);
            end
            useful = n_tests + n_loads - n_dropped;
        end
        steady_run = 1'b0;

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d box tests and %0d plane loads, %0d of them to unused indexes.",
                 n_tests, n_loads, n_dropped);
        $display("Results: %0d inside, %0d intersecting, %0d outside; %0d errors.",
                 vis_seen[VIS_INSIDE], vis_seen[VIS_INTERSECT], vis_seen[VIS_OUTSIDE],
                 err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/aff_pkg.sv
rtl/core/aff_channels.sv
rtl/core/aff_plane_store.sv
rtl/core/aff_mac_unit.sv
rtl/core/aff_sequencer.sv
rtl/core/aabb_frustum_classifier.sv
test/aabb_frustum_classifier_tb.sv
